>>> hdl/circle_pair_collision_finder_assert.svh
// Assertion macros for the circle pair collision finder
`ifndef CIRCLE_PAIR_COLLISION_FINDER_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPCF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPCF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CPCF_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CPCF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hdl/cpcf_pkg.sv
// Shared types and constants for the circle pair collision finder
package cpcf_pkg;
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_UPDATE = 3'd2;
    localparam logic [2:0] CMD_CHECK  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_HANDLE  = 2'd1;
    localparam logic [1:0] KIND_PAIR    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_RM_RD,
        OP_RM_WR,
        OP_UP_RD,
        OP_UP_WR,
        OP_CLEAR,
        OP_CK_RDI,
        OP_CK_RDJ,
        OP_CK_TEST,
        OP_CK_SCAN,
        OP_CK_STORE,
        OP_OUT_ACK,
        OP_OUT_SUM
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] command;
        logic       table_full;
        logic       i_last;
        logic       j_last;
        logic       i_skip;
        logic       pair_hit;
        logic       scan_last;
        logic       scan_found;
        logic       store_full;
        logic       empty;
        logic       rm_last;
    } t_status;
endpackage

>>> hdl/cpcf_datapath.sv
// Datapath: object table, pair store, intersection test and result registers
module cpcf_datapath #(
    parameter int MAX_OBJECTS = 32,
    parameter int MAX_PAIRS   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpcf_pkg::t_cmd      i_cmd,
    output cpcf_pkg::t_status   o_status,
    input  logic                i_cfg_we,
    input  logic [63:0]         i_cfg_data,
    input  logic [2:0]          i_command,
    input  logic [15:0]         i_obj_id,
    input  logic [2:0]          i_obj_type,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [14:0]         i_radius,
    input  logic                i_active,
    output logic [1:0]          o_kind,
    output logic [15:0]         o_handle,
    output logic                o_table_full,
    output logic [15:0]         o_first_id,
    output logic [15:0]         o_second_id,
    output logic [2:0]          o_first_type,
    output logic [2:0]          o_second_type,
    output logic signed [15:0]  o_first_x,
    output logic signed [15:0]  o_first_y,
    output logic signed [15:0]  o_second_x,
    output logic signed [15:0]  o_second_y,
    output logic [5:0]          o_pair_count
);
    localparam int OW = $clog2(MAX_OBJECTS);
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int FW = $clog2(MAX_PAIRS + 1);
    localparam int EW = 16 + 3 + 32 + 15 + 1;

    logic [EW-1:0] r_obj_mem [MAX_OBJECTS];
    logic [31:0]   r_pair_mem [MAX_PAIRS];

    logic [63:0]   r_ignore;
    logic [2:0]    r_command;
    logic [15:0]   r_id;
    logic [2:0]    r_type;
    logic [31:0]   r_pos;
    logic [14:0]   r_rad;
    logic          r_act;
    logic [CW-1:0] r_count;
    logic [15:0]   r_add_cnt;
    logic [FW-1:0] r_fill;
    logic [5:0]    r_added;
    logic [CW-1:0] r_i, r_j, r_w;
    logic [FW-1:0] r_k;
    logic [EW-1:0] r_rd, r_ei, r_ej;
    logic [31:0]   r_prd;
    logic [33:0]   r_dist, r_rsq;

    logic [OW-1:0] n_raddr;
    logic [15:0]   ei_id, ej_id, pf, ps;
    logic [2:0]    ei_ty, ej_ty;
    logic [31:0]   ei_pos, ej_pos;
    logic [14:0]   ei_rad, ej_rad;
    logic          ei_act, ej_act;
    logic signed [16:0] dx, dy;
    logic [15:0]   rsum;
    logic          rd_match;

    assign {ei_id, ei_ty, ei_pos, ei_rad, ei_act} = r_ei;
    assign {ej_id, ej_ty, ej_pos, ej_rad, ej_act} = r_ej;
    assign dx = 17'(signed'(ei_pos[31:16])) - 17'(signed'(ej_pos[31:16]));
    assign dy = 17'(signed'(ei_pos[15:0])) - 17'(signed'(ej_pos[15:0]));
    assign rsum = 16'(ei_rad) + 16'(ej_rad);
    assign pf = r_prd[31:16];
    assign ps = r_prd[15:0];
    assign rd_match = (r_rd[EW-1 -: 16] == r_id) && (r_rd[EW-17 -: 3] == r_type);

    always_comb begin
        case (i_cmd.op)
            cpcf_pkg::OP_CK_RDI: n_raddr = r_i[OW-1:0];
            cpcf_pkg::OP_CK_RDJ: n_raddr = r_j[OW-1:0];
            default:             n_raddr = r_i[OW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= r_obj_mem[n_raddr];
        r_prd <= r_pair_mem[r_k[PW-1:0]];
        r_dist <= 34'(dx * dx) + 34'(dy * dy);
        r_rsq  <= 34'(rsum * rsum);
        if (i_cmd.op == cpcf_pkg::OP_ADD && r_count != CW'(MAX_OBJECTS))
            r_obj_mem[r_count[OW-1:0]] <= {r_id, r_type, r_pos, r_rad, r_act};
        if (i_cmd.op == cpcf_pkg::OP_RM_WR && !rd_match)
            r_obj_mem[r_w[OW-1:0]] <= r_rd;
        if (i_cmd.op == cpcf_pkg::OP_UP_WR && rd_match)
            r_obj_mem[r_i[OW-1:0]] <= {r_rd[EW-1 -: 19], r_pos, r_rd[15:1], r_act};
        if (i_cmd.op == cpcf_pkg::OP_CK_STORE)
            r_pair_mem[r_fill[PW-1:0]] <= {ei_id, ej_id};
        if (i_cmd.op == cpcf_pkg::OP_CK_RDI)
            r_ei <= r_obj_mem[r_i[OW-1:0]];
        if (i_cmd.op == cpcf_pkg::OP_CK_RDJ)
            r_ej <= r_obj_mem[r_j[OW-1:0]];
        if (i_cmd.op == cpcf_pkg::OP_LOAD) begin
            r_command <= i_command;
            r_id <= i_obj_id;
            r_type <= i_obj_type;
            r_pos <= {i_pos_x, i_pos_y};
            r_rad <= i_radius;
            r_act <= i_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore <= '0;
            r_count <= '0;
            r_add_cnt <= '0;
            r_fill <= '0;
            r_added <= '0;
            r_i <= '0;
            r_j <= '0;
            r_w <= '0;
            r_k <= '0;
            o_kind <= '0;
            o_handle <= '0;
            o_table_full <= 1'b0;
            o_first_id <= '0;
            o_second_id <= '0;
            o_first_type <= '0;
            o_second_type <= '0;
            o_first_x <= '0;
            o_first_y <= '0;
            o_second_x <= '0;
            o_second_y <= '0;
            o_pair_count <= '0;
        end else begin
            if (i_cfg_we)
                r_ignore <= i_cfg_data;
            case (i_cmd.op)
                cpcf_pkg::OP_LOAD: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_w <= '0;
                    r_k <= '0;
                    r_added <= '0;
                end
                cpcf_pkg::OP_ADD: begin
                    {o_first_id, o_second_id, o_first_type, o_second_type} <= '0;
                    {o_first_x, o_first_y, o_second_x, o_second_y, o_pair_count} <= '0;
                    o_kind <= cpcf_pkg::KIND_HANDLE;
                    o_handle <= r_add_cnt;
                    o_table_full <= (r_count == CW'(MAX_OBJECTS));
                    if (r_count != CW'(MAX_OBJECTS)) begin
                        r_count <= r_count + 1'b1;
                        r_add_cnt <= r_add_cnt + 1'b1;
                    end
                end
                cpcf_pkg::OP_RM_WR: begin
                    r_i <= r_i + 1'b1;
                    if (!rd_match)
                        r_w <= r_w + 1'b1;
                    if (r_i + 1'b1 == r_count)
                        r_count <= rd_match ? r_w : r_w + 1'b1;
                end
                cpcf_pkg::OP_UP_WR: r_i <= r_i + 1'b1;
                cpcf_pkg::OP_CLEAR: r_fill <= '0;
                cpcf_pkg::OP_CK_RDI: r_j <= '0;
                cpcf_pkg::OP_CK_RDJ: r_k <= '0;
                cpcf_pkg::OP_CK_SCAN: r_k <= r_k + 1'b1;
                cpcf_pkg::OP_CK_STORE: begin
                    r_fill <= r_fill + 1'b1;
                    r_added <= r_added + 1'b1;
                    o_kind <= cpcf_pkg::KIND_PAIR;
                    o_handle <= '0;
                    o_table_full <= 1'b0;
                    o_first_id <= ei_id;
                    o_second_id <= ej_id;
                    o_first_type <= ei_ty;
                    o_second_type <= ej_ty;
                    o_first_x <= ei_pos[31:16];
                    o_first_y <= ei_pos[15:0];
                    o_second_x <= ej_pos[31:16];
                    o_second_y <= ej_pos[15:0];
                    o_pair_count <= '0;
                end
                cpcf_pkg::OP_OUT_ACK, cpcf_pkg::OP_OUT_SUM: begin
                    {o_handle, o_table_full, o_first_id, o_second_id} <= '0;
                    {o_first_type, o_second_type, o_first_x, o_first_y} <= '0;
                    {o_second_x, o_second_y} <= '0;
                    o_kind <= (i_cmd.op == cpcf_pkg::OP_OUT_SUM) ?
                              cpcf_pkg::KIND_SUMMARY : cpcf_pkg::KIND_ACK;
                    o_pair_count <= (i_cmd.op == cpcf_pkg::OP_OUT_SUM) ? r_added : 6'd0;
                end
                default: ;
            endcase
            // j advances after each test; i after each outer row
            if (i_cmd.op == cpcf_pkg::OP_CK_TEST && o_status.j_last)
                r_i <= r_i + 1'b1;
            if (i_cmd.op == cpcf_pkg::OP_CK_TEST)
                r_j <= r_j + 1'b1;
            if (i_cmd.op == cpcf_pkg::OP_CK_RDI && o_status.i_skip)
                r_i <= r_i + 1'b1;
        end
    end

    always_comb begin
        o_status.command    = r_command;
        o_status.table_full = (r_count == CW'(MAX_OBJECTS));
        o_status.empty      = (r_count == '0);
        o_status.i_last     = (r_i + 1'b1 >= r_count);
        o_status.j_last     = (r_j + 1'b1 >= r_count);
        o_status.rm_last    = (r_i + 1'b1 >= r_count);
        o_status.i_skip     = !r_obj_mem[r_i[OW-1:0]][0];
        o_status.pair_hit   = ei_act && ej_act && !(ei_id == ej_id && ei_ty == ej_ty)
                              && !r_ignore[{ei_ty, ej_ty}] && (r_dist <= r_rsq);
        o_status.scan_last  = (r_k + 1'b1 >= r_fill);
        o_status.scan_found = (r_k < r_fill) &&
                              ((pf == ei_id && ps == ej_id) || (pf == ej_id && ps == ei_id));
        o_status.store_full = (r_fill >= FW'(MAX_PAIRS));
    end
endmodule

>>> hdl/cpcf_controller.sv
// Controller: command sequencing and result handshake
module cpcf_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  cpcf_pkg::t_status   i_status,
    output cpcf_pkg::t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RM_RD, S_RM_WR, S_UP_RD, S_UP_WR,
        S_CK_I, S_CK_J, S_CK_WAIT, S_CK_MUL, S_CK_TEST, S_CK_SCAN0, S_CK_SCAN,
        S_EMIT, S_WAITOUT
    } t_state;

    t_state r_state, n_state, n_step;
    logic r_valid, n_valid;
    cpcf_pkg::t_op n_op;

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_cmd.op = n_op;

    always_comb begin
        // next pair, decided on the indexes before they advance
        n_step = (i_status.j_last && i_status.i_last) ? S_EMIT :
                 i_status.j_last ? S_CK_I : S_CK_J;
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        n_op = cpcf_pkg::OP_NONE;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                n_op = cpcf_pkg::OP_LOAD;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_status.command)
                    cpcf_pkg::CMD_ADD: begin
                        n_op = cpcf_pkg::OP_ADD;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    cpcf_pkg::CMD_REMOVE: n_state = i_status.empty ? S_EMIT : S_RM_RD;
                    cpcf_pkg::CMD_UPDATE: n_state = i_status.empty ? S_EMIT : S_UP_RD;
                    cpcf_pkg::CMD_CHECK: n_state = i_status.empty ? S_EMIT : S_CK_I;
                    cpcf_pkg::CMD_CLEAR: begin
                        n_op = cpcf_pkg::OP_CLEAR;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_RM_RD: begin
                n_op = cpcf_pkg::OP_RM_RD;
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                n_op = cpcf_pkg::OP_RM_WR;
                n_state = i_status.rm_last ? S_EMIT : S_RM_RD;
            end
            S_UP_RD: begin
                n_op = cpcf_pkg::OP_UP_RD;
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                n_op = cpcf_pkg::OP_UP_WR;
                n_state = i_status.rm_last ? S_EMIT : S_UP_RD;
            end
            S_CK_I: begin
                n_op = cpcf_pkg::OP_CK_RDI;
                if (i_status.i_skip)
                    n_state = i_status.i_last ? S_EMIT : S_CK_I;
                else
                    n_state = S_CK_J;
            end
            S_CK_J: begin
                n_op = cpcf_pkg::OP_CK_RDJ;
                n_state = S_CK_WAIT;
            end
            S_CK_WAIT: n_state = S_CK_MUL;
            S_CK_MUL: n_state = S_CK_TEST;
            S_CK_TEST: begin
                if (i_status.pair_hit && !i_status.store_full)
                    n_state = S_CK_SCAN0;
                else begin
                    n_op = cpcf_pkg::OP_CK_TEST;
                    n_state = n_step;
                end
            end
            S_CK_SCAN0: n_state = S_CK_SCAN;
            S_CK_SCAN: begin
                if (i_status.scan_found) begin
                    n_op = cpcf_pkg::OP_CK_TEST;
                    n_state = n_step;
                end else if (i_status.scan_last) begin
                    if (!r_valid || i_ready) begin
                        n_op = cpcf_pkg::OP_CK_STORE;
                        n_valid = 1'b1;
                        n_state = S_CK_TEST;
                    end
                end else begin
                    n_op = cpcf_pkg::OP_CK_SCAN;
                    n_state = S_CK_SCAN0;
                end
            end
            S_EMIT: if (!r_valid || i_ready) begin
                n_op = (i_status.command == cpcf_pkg::CMD_CHECK) ?
                       cpcf_pkg::OP_OUT_SUM : cpcf_pkg::OP_OUT_ACK;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule

>>> hdl/circle_pair_collision_finder.sv
// Top level: circle pair collision finder
// Channel | Direction | Handshake
// in      | input     | i_valid / o_ready, command and object fields
// out     | output    | o_valid / i_ready, result fields
// cfg     | input     | i_cfg_we / i_cfg_data, ignore_type_pairs, no wait
// Add loads the command, then writes the object; remove and update read, then write back,
// each table entry in turn. A check takes each pair through CK_J, CK_WAIT, CK_MUL and
// CK_TEST, and on a hit scans the pair store by its single read port, entry by entry.
// Reset is synchronous; table and pair store hold no reset state.
// A stalled result holds the controller until it is taken.
`include "circle_pair_collision_finder_assert.svh"
module circle_pair_collision_finder #(
    parameter int MAX_OBJECTS = 32,
    parameter int MAX_PAIRS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [15:0]        i_obj_id,
    input  logic [2:0]         i_obj_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0]        i_radius,
    input  logic               i_active,
    input  logic               i_cfg_we,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_handle,
    output logic               o_table_full,
    output logic [15:0]        o_first_id,
    output logic [15:0]        o_second_id,
    output logic [2:0]         o_first_type,
    output logic [2:0]         o_second_type,
    output logic signed [15:0] o_first_x,
    output logic signed [15:0] o_first_y,
    output logic signed [15:0] o_second_x,
    output logic signed [15:0] o_second_y,
    output logic [5:0]         o_pair_count
);
    cpcf_pkg::t_cmd    cmd;
    cpcf_pkg::t_status status;

    cpcf_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_status(status), .o_cmd(cmd)
    );

    cpcf_datapath #(.MAX_OBJECTS(MAX_OBJECTS), .MAX_PAIRS(MAX_PAIRS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_command(i_command), .i_obj_id(i_obj_id), .i_obj_type(i_obj_type),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_radius(i_radius), .i_active(i_active),
        .o_kind(o_kind), .o_handle(o_handle), .o_table_full(o_table_full),
        .o_first_id(o_first_id), .o_second_id(o_second_id),
        .o_first_type(o_first_type), .o_second_type(o_second_type),
        .o_first_x(o_first_x), .o_first_y(o_first_y),
        .o_second_x(o_second_x), .o_second_y(o_second_y), .o_pair_count(o_pair_count)
    );

    `CPCF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready after accept")
    `CPCF_ASSERT_IMPL(a_no_ready_while_out, i_clk, i_rst_n, o_valid |-> !o_ready, "ready with pending result")
    `CPCF_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, !(o_valid && o_kind == cpcf_pkg::KIND_SUMMARY && o_pair_count > 6'(MAX_PAIRS)), "summary count too large")
endmodule
